@@ sv/dtsa_pkg.sv @@
// shared types and constants for the distance trend speed adjuster
// no dependencies

package dtsa_pkg;

    localparam int DistW   = 8;
    localparam int SecW    = 6;
    localparam int SpeedW  = 8;
    localparam int CountW  = 8;
    localparam int DeltaW  = 7;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 8;

    typedef enum logic [CfgIdxW-1:0] {
        REG_NEAR_WINDOW      = 3'd0,
        REG_FAR_WINDOW_MIN   = 3'd1,
        REG_RELEASE_DISTANCE = 3'd2,
        REG_TREND_DELTA      = 3'd3,
        REG_RESUME_LIMIT     = 3'd4,
        REG_FLOOR_SPEED      = 3'd5,
        REG_SPEED_STEP       = 3'd6,
        REG_CUTOFF_SPEED     = 3'd7
    } cfg_index_t;

    localparam logic [DistW-1:0]  RstNearWindow     = 8'd50;
    localparam logic [DistW-1:0]  RstFarWindowMin   = 8'd20;
    localparam logic [DistW-1:0]  RstReleaseDist    = 8'd50;
    localparam logic [DeltaW-1:0] RstTrendDelta     = 7'd3;
    localparam logic [SpeedW-1:0] RstResumeLimit    = 8'd90;
    localparam logic [SpeedW-1:0] RstFloorSpeed     = 8'd70;
    localparam logic [SpeedW-1:0] RstSpeedStep      = 8'd4;
    localparam logic [SpeedW-1:0] RstCutoffSpeed    = 8'd99;

    typedef struct packed {
        logic [DistW-1:0]  near_window;
        logic [DistW-1:0]  far_window_min;
        logic [DistW-1:0]  release_distance;
        logic [DeltaW-1:0] trend_delta;
        logic [SpeedW-1:0] resume_limit;
        logic [SpeedW-1:0] floor_speed;
        logic [SpeedW-1:0] speed_step;
        logic [SpeedW-1:0] cutoff_speed;
    } cfg_t;

    typedef struct packed {
        logic [DistW-1:0]  distance;
        logic [SecW-1:0]   seconds;
        logic              drowsy_level_one;
        logic [SpeedW-1:0] current_speed;
    } in_item_t;

    typedef struct packed {
        logic [SpeedW-1:0] new_speed;
        logic              speed_applied;
        logic [CountW-1:0] slowdown_count;
    } out_item_t;

endpackage

@@ sv/distance_trend_speed_adjuster.sv @@
// top level of the distance trend speed adjuster: stream ports, input and result registers
// depends on dtsa_pkg, dtsa_cfg, dtsa_core

// Takes one item per clock while s_tready is high and returns one result item for each,
// through the input register and then the result register. The decision for an item is a
// single pass of compares and 8-bit adds on the registered item and the trend state,
// so sustained throughput is one item per cycle; a stalled result register holds
// the pipe and s_tready drops only when both registers are full and m_tready is low.
// Configuration writes are always ready and take effect on the next cycle; they are
// meant to be made while no item is in flight.

module distance_trend_speed_adjuster (
    input  logic        aclk,
    input  logic        aresetn,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // distance [7:0], seconds [13:8], current_speed [21:14], zero
    input  logic        s_tuser,   // drowsy_level_one

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // new_speed [7:0], slowdown_count [15:8]
    output logic        m_tuser,   // speed_applied

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    dtsa_pkg::cfg_t      cfg;
    dtsa_pkg::in_item_t  in_item_reg;
    dtsa_pkg::in_item_t  in_item_next;
    dtsa_pkg::out_item_t out_item_reg;
    dtsa_pkg::out_item_t res;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                s_fire;

    // the result register can take a value; the core steps when it also holds an item
    assign advance = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_item_next.distance         = s_tdata[7:0];
        in_item_next.seconds          = s_tdata[13:8];
        in_item_next.current_speed    = s_tdata[21:14];
        in_item_next.drowsy_level_one = s_tuser;
    end

    dtsa_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dtsa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_valid_reg && advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // control: valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
        if (in_valid_reg && advance) begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_item_reg.slowdown_count, out_item_reg.new_speed};
    assign m_tuser  = out_item_reg.speed_applied;

`ifndef ASSERT_OFF
    // back pressure only with both stages full and the sink stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipe");

    // an accepted item reaches the input stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> in_valid_reg)
        else $error("accepted item lost");

    // a stalled result does not move
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
`endif

endmodule

@@ sv/dtsa_cfg.sv @@
// configuration register file for the distance trend speed adjuster
// depends on dtsa_pkg

module dtsa_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [dtsa_pkg::CfgIdxW-1:0]  wr_index,
    input  logic [dtsa_pkg::CfgDatW-1:0]  wr_data,
    output dtsa_pkg::cfg_t                cfg
);

    dtsa_pkg::cfg_t cfg_reg;
    dtsa_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (dtsa_pkg::cfg_index_t'(wr_index))
                dtsa_pkg::REG_NEAR_WINDOW:      cfg_next.near_window      = wr_data;
                dtsa_pkg::REG_FAR_WINDOW_MIN:   cfg_next.far_window_min   = wr_data;
                dtsa_pkg::REG_RELEASE_DISTANCE: cfg_next.release_distance = wr_data;
                dtsa_pkg::REG_TREND_DELTA:
                    cfg_next.trend_delta = wr_data[dtsa_pkg::DeltaW-1:0];
                dtsa_pkg::REG_RESUME_LIMIT:     cfg_next.resume_limit     = wr_data;
                dtsa_pkg::REG_FLOOR_SPEED:      cfg_next.floor_speed      = wr_data;
                dtsa_pkg::REG_SPEED_STEP:       cfg_next.speed_step       = wr_data;
                dtsa_pkg::REG_CUTOFF_SPEED:     cfg_next.cutoff_speed     = wr_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_window      <= dtsa_pkg::RstNearWindow;
            cfg_reg.far_window_min   <= dtsa_pkg::RstFarWindowMin;
            cfg_reg.release_distance <= dtsa_pkg::RstReleaseDist;
            cfg_reg.trend_delta      <= dtsa_pkg::RstTrendDelta;
            cfg_reg.resume_limit     <= dtsa_pkg::RstResumeLimit;
            cfg_reg.floor_speed      <= dtsa_pkg::RstFloorSpeed;
            cfg_reg.speed_step       <= dtsa_pkg::RstSpeedStep;
            cfg_reg.cutoff_speed     <= dtsa_pkg::RstCutoffSpeed;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/dtsa_core.sv @@
// trend state and one-pass speed decision for the distance trend speed adjuster
// depends on dtsa_pkg

module dtsa_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dtsa_pkg::in_item_t  item,
    input  dtsa_pkg::cfg_t      cfg,
    output dtsa_pkg::out_item_t res
);

    logic [dtsa_pkg::CountW-1:0] pending_reg,     pending_next;
    logic [dtsa_pkg::DistW-1:0]  near_first_reg,  near_first_next;
    logic                        near_armed_reg,  near_armed_next;
    logic [dtsa_pkg::DistW-1:0]  far_first_reg,   far_first_next;
    logic                        far_armed_reg,   far_armed_next;
    logic [dtsa_pkg::SecW-1:0]   last_sec_reg,    last_sec_next;

    logic                         act;
    logic                         near_in;
    logic                         far_in;
    logic [dtsa_pkg::DistW-1:0]   near_diff;
    logic [dtsa_pkg::DistW-1:0]   far_diff;
    logic signed [dtsa_pkg::DistW-1:0] delta_s;
    logic                         closing;
    logic                         open_run;
    logic                         opening;
    logic                         recover;
    logic [dtsa_pkg::SpeedW-1:0]  up_speed;
    logic [dtsa_pkg::SpeedW-1:0]  speed_out;

    always_comb begin
        act       = item.drowsy_level_one && (item.seconds != last_sec_reg);
        near_in   = item.distance <= cfg.near_window;
        far_in    = item.distance >= cfg.far_window_min;
        near_diff = near_first_reg - item.distance;
        far_diff  = item.distance - far_first_reg;
        delta_s   = $signed({1'b0, cfg.trend_delta});
        closing   = act && near_in && near_armed_reg && ($signed(near_diff) >= delta_s);
        open_run  = act && !closing;
        opening   = open_run && far_in && far_armed_reg && ($signed(far_diff) >= delta_s);
        recover   = open_run && (pending_reg != '0)
                    && ((opening && (item.current_speed <= cfg.resume_limit))
                        || (item.distance >= cfg.release_distance));

        if (item.current_speed < cfg.floor_speed) begin
            up_speed = cfg.floor_speed;
        end else begin
            up_speed = item.current_speed + cfg.speed_step;
        end

        speed_out = item.current_speed;
        if (closing) begin
            speed_out = (item.current_speed <= cfg.floor_speed) ? '0
                        : item.current_speed - cfg.speed_step;
        end else if (recover) begin
            speed_out = (up_speed >= cfg.cutoff_speed) ? '0 : up_speed;
        end
    end

    always_comb begin
        near_first_next = near_first_reg;
        near_armed_next = near_armed_reg;
        far_first_next  = far_first_reg;
        far_armed_next  = far_armed_reg;
        last_sec_next   = last_sec_reg;
        pending_next    = pending_reg;

        if (act) begin
            last_sec_next = item.seconds;
            if (near_in) begin
                if (!near_armed_reg) begin
                    near_first_next = item.distance;
                end
                near_armed_next = !near_armed_reg;
            end else begin
                near_first_next = '0;
            end
        end

        if (open_run) begin
            if (far_in) begin
                if (!far_armed_reg) begin
                    far_first_next = item.distance;
                end
                far_armed_next = !far_armed_reg;
            end else begin
                far_first_next = '0;
            end
        end

        if (!item.drowsy_level_one) begin
            pending_next = '0;
        end else if (closing) begin
            pending_next = pending_reg + dtsa_pkg::CountW'(1);
        end else if (recover) begin
            pending_next = pending_reg - dtsa_pkg::CountW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= '0;
            near_first_reg <= '0;
            near_armed_reg <= 1'b0;
            far_first_reg  <= '0;
            far_armed_reg  <= 1'b0;
            last_sec_reg   <= '0;
        end else if (step) begin
            pending_reg    <= pending_next;
            near_first_reg <= near_first_next;
            near_armed_reg <= near_armed_next;
            far_first_reg  <= far_first_next;
            far_armed_reg  <= far_armed_next;
            last_sec_reg   <= last_sec_next;
        end
    end

    assign res.new_speed      = speed_out;
    assign res.speed_applied  = closing || recover;
    assign res.slowdown_count = pending_next;

`ifndef ASSERT_OFF
    // the reported count is the count that is kept
    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (pending_reg == $past(res.slowdown_count)))
        else $error("slowdown count state differs from reported count");

    // no drowsiness clears the count
    a_clear_on_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !item.drowsy_level_one) |=> (pending_reg == '0))
        else $error("count not cleared with drowsy flag low");

    // an unchanged second leaves the pair state alone
    a_same_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (item.seconds == last_sec_reg)) |=>
            ($stable(near_first_reg) && $stable(near_armed_reg)
             && $stable(far_first_reg) && $stable(far_armed_reg)))
        else $error("pair state changed within the same second");

    // closing and recovery never both fire on a held item
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(closing && recover))
        else $error("closing and recovery at once");
`endif

endmodule
